// ----- src/snh_pkg.sv -----
// Shared types and codes for the surface normal at hit block.
// Used by the object table and by the top level; depends on nothing.
`timescale 1ns / 1ps

package snh_pkg;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        SHAPE_SPHERE   = 2'd0,
        SHAPE_CYLINDER = 2'd1,
        SHAPE_CONE     = 2'd2,
        SHAPE_PLANE    = 2'd3
    } t_shape;

    // One object table entry.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic [7:0]         material;
    } t_obj;

endpackage

// ----- src/surface_normal_at_hit.sv -----
// Surface normal at a ray hit for a table of quadric objects.
// Uses snh_pkg, snh_obj_mem, snh_sqrt and snh_div.
//
// Usage: one input stream carries requests. tuser = 0 is a load that writes
// one object slot (position, axis, material) and gives no result; tuser = 1
// is a query that forms the hit point, the shape's raw normal, and returns
// the unit normal with the slot's material on the output stream. valid_res
// (output tuser) is 0 when the raw normal has zero length.
// Throughput: one request per cycle while the output is taken. The block is
// one pipeline around the object table. Most of its length is in the square
// root unit (one result bit per stage, 25 stages) and the divider (one
// quotient bit per stage, 17 stages). The table is read in the cycle of
// acceptance; a load is written at its own acceptance edge, so every later
// query sees it.
// Stall: all stages move together; while the output register holds a result
// that the receiver does not take, input tready is low and nothing moves.
// Reset clears every stage's valid bit; the table contents are not cleared,
// and a slot must be loaded before it is queried.
`timescale 1ns / 1ps

module surface_normal_at_hit #(
    parameter int OBJECT_SLOTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // slot[5:0], shape[7:6], material_in[15:8], vec_a_x[47:16], vec_a_y[79:48],
    // vec_a_z[111:80], vec_b_x[143:112], vec_b_y[175:144], vec_b_z[207:176],
    // hit_distance[238:208], zero[239]
    input  logic [239:0] i_s_axis_tdata,
    // kind[0]
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // normal_x[17:0], normal_y[35:18], normal_z[53:36], material_out[61:54],
    // zero[63:62]
    output logic [63:0]  o_m_axis_tdata,
    // valid_res[0]
    output logic [0:0]   o_m_axis_tuser
);

    localparam int AW     = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
    localparam int PW_SQ  = 8 + 1 + 3 + 3 * 24;
    localparam int PW_DV  = 8 + 1 + 3;

    typedef logic signed [31:0] t_s32;

    function automatic t_s32 sat32(input logic signed [63:0] x);
        t_s32 r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] mul32(input t_s32 a, input t_s32 b);
        logic signed [63:0] p;
        p = a * b;
        return p;
    endfunction

    function automatic logic [AW-1:0] slot_index(input logic [5:0] s);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (s == 6'(i)) idx = AW'(i % OBJECT_SLOTS);
        end
        return idx;
    endfunction

    // Input unpacking
    logic               w_accept;
    logic               w_adv;
    logic               w_kind;
    logic [5:0]         w_slot;
    snh_pkg::t_shape    w_shape;
    logic [30:0]        w_hit;
    t_s32               w_va [3];
    t_s32               w_vb [3];
    snh_pkg::t_obj      w_wobj;
    snh_pkg::t_obj      w_robj;

    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid && w_adv;
    assign w_kind          = i_s_axis_tuser[0];
    assign w_slot          = i_s_axis_tdata[5:0];
    assign w_shape         = snh_pkg::t_shape'(i_s_axis_tdata[7:6]);
    assign w_hit           = i_s_axis_tdata[238:208];
    assign w_va[0]         = i_s_axis_tdata[47:16];
    assign w_va[1]         = i_s_axis_tdata[79:48];
    assign w_va[2]         = i_s_axis_tdata[111:80];
    assign w_vb[0]         = i_s_axis_tdata[143:112];
    assign w_vb[1]         = i_s_axis_tdata[175:144];
    assign w_vb[2]         = i_s_axis_tdata[207:176];

    assign w_wobj.pos_x    = w_va[0];
    assign w_wobj.pos_y    = w_va[1];
    assign w_wobj.pos_z    = w_va[2];
    assign w_wobj.axis_x   = w_vb[0];
    assign w_wobj.axis_y   = w_vb[1];
    assign w_wobj.axis_z   = w_vb[2];
    assign w_wobj.material = i_s_axis_tdata[15:8];

    snh_obj_mem #(
        .DEPTH (OBJECT_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_accept && (w_kind == snh_pkg::KIND_LOAD)),
        .i_waddr (slot_index(w_slot)),
        .i_wdata (w_wobj),
        .i_re    (w_adv),
        .i_raddr (slot_index(w_slot)),
        .o_rdata (w_robj)
    );

    // Pipeline registers
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic r_v11, r_v12, r_v13, r_v14;

    snh_pkg::t_shape r_shape1, r_shape2, r_shape3, r_shape4, r_shape5;
    snh_pkg::t_shape r_shape6, r_shape7;
    logic [30:0]     r_t1;
    t_s32            r_dir1 [3];
    t_s32            r_start1 [3];
    t_s32            r_start2 [3];
    logic signed [63:0] r_prod2 [3];
    snh_pkg::t_obj   r_obj2, r_obj3;
    t_s32            r_p3 [3];
    t_s32            r_a4 [3], r_a5 [3], r_a6 [3], r_a7 [3];
    t_s32            r_b4 [3], r_b5 [3], r_b6 [3];
    t_s32            r_axis4 [3], r_axis5 [3], r_axis6 [3], r_axis7 [3];
    logic [7:0]      r_mat4, r_mat5, r_mat6, r_mat7, r_mat8, r_mat9, r_mat10;
    logic [7:0]      r_mat11, r_mat12, r_mat13;
    logic signed [63:0] r_pr5 [6];
    t_s32            r_c6 [3];
    logic signed [63:0] r_pr7 [6];
    t_s32            r_raw8 [3];
    logic [31:0]     r_mag9 [3], r_mag10 [3];
    logic [2:0]      r_neg9, r_neg10, r_neg11, r_neg12, r_neg13;
    logic [31:0]     r_max9;
    logic [4:0]      r_lz10;
    logic            r_ok10, r_ok11, r_ok12, r_ok13;
    logic [23:0]     r_sc11 [3], r_sc12 [3], r_sc13 [3];
    logic [47:0]     r_sq12 [3];
    logic [49:0]     r_sum13;
    logic [40:0]     r_num14 [3];
    logic [24:0]     r_root14;
    logic [PW_DV-1:0] r_pay14;

    logic            r_ov;
    logic [17:0]     r_n [3];
    logic [7:0]      r_mat_o;
    logic            r_ok_o;

    // Next values of the combinational stages
    t_s32            n_p [3];
    t_s32            n_a [3], n_b [3], n_axis [3];
    logic signed [63:0] n_pr5 [6], n_pr7 [6];
    t_s32            n_c6 [3], n_c8 [3], n_raw [3], n_left [3];
    logic [31:0]     n_mag [3];
    logic [2:0]      n_neg;
    logic [31:0]     n_max;
    logic [4:0]      n_lz;
    logic [23:0]     n_sc [3];
    logic [40:0]     n_num [3];

    logic             w_sq_v;
    logic [24:0]      w_root;
    logic [PW_SQ-1:0] w_sq_pay;
    logic             w_dv_v;
    logic [16:0]      w_quot [3];
    logic [PW_DV-1:0] w_dv_pay;
    logic [40:0]      w_dnum [3];

    always_comb begin
        logic [31:0] x;
        logic [31:0] sh;
        int j;
        int k;
        for (int i = 0; i < 3; i++) begin
            n_p[i] = sat32(64'(r_start2[i]) + 64'(sat32(r_prod2[i] >>> 16)));
        end
        n_axis[0] = r_obj3.axis_x;
        n_axis[1] = r_obj3.axis_y;
        n_axis[2] = r_obj3.axis_z;
        n_a[0] = sat32(64'(r_p3[0]) - 64'(r_obj3.pos_x));
        n_a[1] = sat32(64'(r_p3[1]) - 64'(r_obj3.pos_y));
        n_a[2] = sat32(64'(r_p3[2]) - 64'(r_obj3.pos_z));
        n_b[0] = sat32(64'(r_obj3.pos_x) - 64'(r_p3[0]));
        n_b[1] = sat32(64'(r_obj3.pos_y) - 64'(r_p3[1]));
        n_b[2] = sat32(64'(r_obj3.pos_z) - 64'(r_p3[2]));
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            n_pr5[2*i]     = mul32(r_axis4[j], r_a4[k]);
            n_pr5[2*i + 1] = mul32(r_axis4[k], r_a4[j]);
            n_c6[i]   = sat32((r_pr5[2*i] >>> 16) - (r_pr5[2*i + 1] >>> 16));
            n_left[i] = (r_shape6 == snh_pkg::SHAPE_CYLINDER) ? r_axis6[i] : r_b6[i];
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            n_pr7[2*i]     = mul32(n_left[j], r_c6[k]);
            n_pr7[2*i + 1] = mul32(n_left[k], r_c6[j]);
            n_c8[i] = sat32((r_pr7[2*i] >>> 16) - (r_pr7[2*i + 1] >>> 16));
            case (r_shape7)
                snh_pkg::SHAPE_SPHERE: n_raw[i] = r_a7[i];
                snh_pkg::SHAPE_PLANE:  n_raw[i] = r_axis7[i];
                default:               n_raw[i] = n_c8[i];
            endcase
        end
        // Magnitudes; the most negative value maps to 2^31.
        n_max = '0;
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = r_raw8[i][31];
            n_mag[i] = r_raw8[i][31] ? (~r_raw8[i] + 32'd1) : r_raw8[i];
            if (n_mag[i] > n_max) n_max = n_mag[i];
        end
        // Leading zero count in five halving steps.
        x    = r_max9;
        n_lz = '0;
        if (x[31:16] == '0) begin x = x << 16; n_lz[4] = 1'b1; end
        if (x[31:24] == '0) begin x = x << 8;  n_lz[3] = 1'b1; end
        if (x[31:28] == '0) begin x = x << 4;  n_lz[2] = 1'b1; end
        if (x[31:30] == '0) begin x = x << 2;  n_lz[1] = 1'b1; end
        if (x[31] == 1'b0)  begin n_lz[0] = 1'b1; end
        // Shifting the largest magnitude up to bit 31 and dropping eight bits
        // puts its top bit at bit 23, truncating the others the same way.
        for (int i = 0; i < 3; i++) begin
            sh = r_mag10[i] << r_lz10;
            n_sc[i] = sh[31:8];
        end
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {1'b0, w_sq_pay[24*i +: 24], 16'd0} + 41'(w_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0; r_v2  <= 1'b0; r_v3  <= 1'b0; r_v4  <= 1'b0;
            r_v5  <= 1'b0; r_v6  <= 1'b0; r_v7  <= 1'b0; r_v8  <= 1'b0;
            r_v9  <= 1'b0; r_v10 <= 1'b0; r_v11 <= 1'b0; r_v12 <= 1'b0;
            r_v13 <= 1'b0; r_v14 <= 1'b0; r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_v1  <= w_accept && (w_kind == snh_pkg::KIND_QUERY);
            r_v2  <= r_v1;  r_v3  <= r_v2;  r_v4  <= r_v3;  r_v5  <= r_v4;
            r_v6  <= r_v5;  r_v7  <= r_v6;  r_v8  <= r_v7;  r_v9  <= r_v8;
            r_v10 <= r_v9;  r_v11 <= r_v10; r_v12 <= r_v11; r_v13 <= r_v12;
            r_v14 <= w_sq_v;
            r_ov  <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_shape1 <= w_shape;
            r_t1     <= w_hit;
            r_shape2 <= r_shape1;
            r_obj2   <= w_robj;
            r_shape3 <= r_shape2;
            r_obj3   <= r_obj2;
            r_shape4 <= r_shape3;
            r_mat4   <= r_obj3.material;
            r_shape5 <= r_shape4;
            r_mat5   <= r_mat4;
            r_shape6 <= r_shape5;
            r_mat6   <= r_mat5;
            r_shape7 <= r_shape6;
            r_mat7   <= r_mat6;
            r_mat8   <= r_mat7;
            r_neg9   <= n_neg;
            r_max9   <= n_max;
            r_mat9   <= r_mat8;
            r_neg10  <= r_neg9;
            r_lz10   <= n_lz;
            r_ok10   <= (r_max9 != '0);
            r_mat10  <= r_mat9;
            r_neg11  <= r_neg10;
            r_ok11   <= r_ok10;
            r_mat11  <= r_mat10;
            r_neg12  <= r_neg11;
            r_ok12   <= r_ok11;
            r_mat12  <= r_mat11;
            r_sum13  <= 50'(r_sq12[0]) + 50'(r_sq12[1]) + 50'(r_sq12[2]);
            r_neg13  <= r_neg12;
            r_ok13   <= r_ok12;
            r_mat13  <= r_mat12;
            r_root14 <= w_root;
            r_pay14  <= w_sq_pay[PW_SQ-1:72];
            for (int i = 0; i < 3; i++) begin
                r_dir1[i]   <= w_vb[i];
                r_start1[i] <= w_va[i];
                r_start2[i] <= r_start1[i];
                r_prod2[i]  <= mul32(t_s32'({1'b0, r_t1}), r_dir1[i]);
                r_p3[i]     <= n_p[i];
                r_a4[i]     <= n_a[i];
                r_b4[i]     <= n_b[i];
                r_axis4[i]  <= n_axis[i];
                r_a5[i]     <= r_a4[i];
                r_b5[i]     <= r_b4[i];
                r_axis5[i]  <= r_axis4[i];
                r_a6[i]     <= r_a5[i];
                r_b6[i]     <= r_b5[i];
                r_axis6[i]  <= r_axis5[i];
                r_c6[i]     <= n_c6[i];
                r_a7[i]     <= r_a6[i];
                r_axis7[i]  <= r_axis6[i];
                r_raw8[i]   <= n_raw[i];
                r_mag9[i]   <= n_mag[i];
                r_mag10[i]  <= r_mag9[i];
                r_sc11[i]   <= n_sc[i];
                r_sc12[i]   <= r_sc11[i];
                r_sq12[i]   <= 48'(r_sc11[i]) * 48'(r_sc11[i]);
                r_sc13[i]   <= r_sc12[i];
                r_num14[i]  <= n_num[i];
            end
            for (int i = 0; i < 6; i++) begin
                r_pr5[i] <= n_pr5[i];
                r_pr7[i] <= n_pr7[i];
            end
        end
    end

    snh_sqrt #(
        .VW (50),
        .PW (PW_SQ)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v13),
        .i_rad   (r_sum13),
        .i_pay   ({r_mat13, r_ok13, r_neg13, r_sc13[2], r_sc13[1], r_sc13[0]}),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_pay   (w_sq_pay)
    );

    assign w_dnum[0] = r_num14[0];
    assign w_dnum[1] = r_num14[1];
    assign w_dnum[2] = r_num14[2];

    snh_div #(
        .NW    (41),
        .DW    (25),
        .QW    (17),
        .LANES (3),
        .PW    (PW_DV)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v14),
        .i_num   (w_dnum),
        .i_den   (r_root14),
        .i_pay   (r_pay14),
        .o_valid (w_dv_v),
        .o_quot  (w_quot),
        .o_pay   (w_dv_pay)
    );

    // Output register: sign applied, zero-length vectors forced to zero.
    always_ff @(posedge i_clk) begin
        logic [17:0] q;
        if (w_adv) begin
            r_mat_o <= w_dv_pay[11:4];
            r_ok_o  <= w_dv_pay[3];
            for (int i = 0; i < 3; i++) begin
                q = {1'b0, w_quot[i]};
                if (!w_dv_pay[3]) begin
                    r_n[i] <= '0;
                end else if (w_dv_pay[i]) begin
                    r_n[i] <= -q;
                end else begin
                    r_n[i] <= q;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_mat_o, r_n[2], r_n[1], r_n[0]};
    assign o_m_axis_tuser  = r_ok_o;

    // A load never starts a result.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_kind == snh_pkg::KIND_LOAD)) |=> !r_v1)
        else $error("load request entered the result pipeline");

    // A zero-length normal is reported as all zeros.
    a_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
        (o_m_axis_tdata[53:0] == 54'd0))
        else $error("invalid normal carries nonzero components");

    // Valid normal components stay within unit range.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        ($signed(o_m_axis_tdata[17:0]) <= 18'sd65536 &&
         $signed(o_m_axis_tdata[17:0]) >= -18'sd65536 &&
         $signed(o_m_axis_tdata[35:18]) <= 18'sd65536 &&
         $signed(o_m_axis_tdata[35:18]) >= -18'sd65536 &&
         $signed(o_m_axis_tdata[53:36]) <= 18'sd65536 &&
         $signed(o_m_axis_tdata[53:36]) >= -18'sd65536))
        else $error("normal component out of unit range");

endmodule

// ----- src/snh_obj_mem.sv -----
// Object table: one synchronous memory, one write port, one registered read port.
// Depends on snh_pkg for the entry type.
`timescale 1ns / 1ps

module snh_obj_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  snh_pkg::t_obj     i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output snh_pkg::t_obj     o_rdata
);

    snh_pkg::t_obj r_mem [DEPTH];
    snh_pkg::t_obj r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/snh_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side payload.
// Standalone; used by the top level for the vector length.
`timescale 1ns / 1ps

module snh_sqrt #(
    parameter int VW = 50,
    parameter int PW = 84
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [VW-1:0]       i_rad,
    input  logic [PW-1:0]       i_pay,
    output logic                o_valid,
    output logic [VW/2-1:0]     o_root,
    output logic [PW-1:0]       o_pay
);

    localparam int ITER = VW / 2;
    localparam int W    = VW + 1;

    logic          r_v   [ITER];
    logic [W-1:0]  r_rem [ITER];
    logic [W-1:0]  r_res [ITER];
    logic [PW-1:0] r_pay [ITER];

    logic          s_v   [ITER];
    logic [W-1:0]  s_rem [ITER];
    logic [W-1:0]  s_res [ITER];
    logic [PW-1:0] s_pay [ITER];
    logic [W-1:0]  n_rem [ITER];
    logic [W-1:0]  n_res [ITER];

    always_comb begin
        logic [W-1:0] bitv;
        logic [W-1:0] trial;
        s_v[0]   = i_valid;
        s_rem[0] = W'(i_rad);
        s_res[0] = '0;
        s_pay[0] = i_pay;
        for (int k = 1; k < ITER; k++) begin
            s_v[k]   = r_v[k-1];
            s_rem[k] = r_rem[k-1];
            s_res[k] = r_res[k-1];
            s_pay[k] = r_pay[k-1];
        end
        for (int k = 0; k < ITER; k++) begin
            bitv  = W'(1) << (2 * (ITER - 1 - k));
            trial = s_res[k] + bitv;
            if (s_rem[k] >= trial) begin
                n_rem[k] = s_rem[k] - trial;
                n_res[k] = (s_res[k] >> 1) + bitv;
            end else begin
                n_rem[k] = s_rem[k];
                n_res[k] = s_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ITER; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < ITER; k++) r_v[k] <= s_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ITER; k++) begin
                r_rem[k] <= n_rem[k];
                r_res[k] <= n_res[k];
                r_pay[k] <= s_pay[k];
            end
        end
    end

    assign o_valid = r_v[ITER-1];
    assign o_root  = r_res[ITER-1][ITER-1:0];
    assign o_pay   = r_pay[ITER-1];

endmodule

// ----- src/snh_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a side payload. Standalone.
`timescale 1ns / 1ps

module snh_div #(
    parameter int NW    = 41,
    parameter int DW    = 25,
    parameter int QW    = 17,
    parameter int LANES = 3,
    parameter int PW    = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num [LANES],
    input  logic [DW-1:0]   i_den,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [QW-1:0]   o_quot [LANES],
    output logic [PW-1:0]   o_pay
);

    localparam int CW = NW + 1;

    logic          r_v   [QW];
    logic [CW-1:0] r_rem [QW][LANES];
    logic [QW-1:0] r_q   [QW][LANES];
    logic [DW-1:0] r_den [QW];
    logic [PW-1:0] r_pay [QW];

    logic          s_v   [QW];
    logic [CW-1:0] s_rem [QW][LANES];
    logic [QW-1:0] s_q   [QW][LANES];
    logic [DW-1:0] s_den [QW];
    logic [PW-1:0] s_pay [QW];
    logic [CW-1:0] n_rem [QW][LANES];
    logic [QW-1:0] n_q   [QW][LANES];

    always_comb begin
        logic [CW-1:0] sub;
        s_v[0]   = i_valid;
        s_den[0] = i_den;
        s_pay[0] = i_pay;
        for (int l = 0; l < LANES; l++) begin
            s_rem[0][l] = CW'(i_num[l]);
            s_q[0][l]   = '0;
        end
        for (int k = 1; k < QW; k++) begin
            s_v[k]   = r_v[k-1];
            s_den[k] = r_den[k-1];
            s_pay[k] = r_pay[k-1];
            for (int l = 0; l < LANES; l++) begin
                s_rem[k][l] = r_rem[k-1][l];
                s_q[k][l]   = r_q[k-1][l];
            end
        end
        for (int k = 0; k < QW; k++) begin
            sub = CW'(s_den[k]) << (QW - 1 - k);
            for (int l = 0; l < LANES; l++) begin
                if (s_rem[k][l] >= sub) begin
                    n_rem[k][l] = s_rem[k][l] - sub;
                    n_q[k][l]   = {s_q[k][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = s_rem[k][l];
                    n_q[k][l]   = {s_q[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < QW; k++) r_v[k] <= s_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_den[k] <= s_den[k];
                r_pay[k] <= s_pay[k];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_q[k][l]   <= n_q[k][l];
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_pay   = r_pay[QW-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) o_quot[l] = r_q[QW-1][l];
    end

endmodule
